// ===== design/capab_pkg.sv =====
// Shared types and constants for the capsule versus box penetration block.
package capab_pkg;

  // Unit length in Q16.16.
  localparam logic [16:0] ONE_Q16 = 17'h10000;
  // Largest depth value that the result can carry.
  localparam logic [30:0] DEPTH_MAX = 31'h7FFF_FFFF;
  // Depth of the queue between the classifier and the solver.
  localparam int unsigned QDEPTH = 2;

  // Axis chosen for an inside push-out.
  typedef enum logic [1:0] {
    AX_X,
    AX_Y,
    AX_Z
  } axis_t;

  // One classified query, as the front hands it to the back.
  typedef struct packed {
    logic               hit;
    logic               interior;
    logic [61:0]        l2;
    logic signed [31:0] dx;
    logic signed [31:0] dy;
    logic signed [31:0] dz;
    logic [30:0]        rad;
    axis_t              ax;
    logic               neg;
    logic [30:0]        dep_in;
  } job_t;

endpackage

// ===== design/capab_front.sv =====
// Front part: clamps, squared distances, test selection and inside push-out.
module capab_front import capab_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               take,
  input  logic signed [31:0] center_x,
  input  logic signed [31:0] center_y,
  input  logic signed [31:0] center_z,
  input  logic [30:0]        half_height,
  input  logic [30:0]        radius,
  input  logic signed [31:0] box_min_x,
  input  logic signed [31:0] box_min_y,
  input  logic signed [31:0] box_min_z,
  input  logic signed [31:0] box_max_x,
  input  logic signed [31:0] box_max_y,
  input  logic signed [31:0] box_max_z,
  output logic               push,
  output job_t               job
);

  // Offset from a point to the box clamped along one axis.
  function automatic logic signed [34:0] clamp_d(input logic signed [33:0] c,
                                                 input logic signed [31:0] lo,
                                                 input logic signed [31:0] hi);
    logic signed [33:0] q;
    begin
      if (c < 34'(lo)) q = 34'(lo);
      else if (c > 34'(hi)) q = 34'(hi);
      else q = c;
      clamp_d = 35'(c) - 35'(q);
    end
  endfunction

  // True when an offset lies within plus or minus the radius.
  function automatic logic in_rng(input logic signed [34:0] d, input logic [30:0] r);
    logic signed [34:0] rs;
    begin
      rs = $signed({4'b0, r});
      in_rng = (d <= rs) && (d >= -rs);
    end
  endfunction

  // Distance to the nearer of the two faces on one axis.
  function automatic logic [34:0] face_dist(input logic signed [33:0] c,
                                            input logic signed [31:0] lo,
                                            input logic signed [31:0] hi);
    logic signed [34:0] a;
    logic signed [34:0] b;
    logic [34:0] aa;
    logic [34:0] ab;
    begin
      a = 35'(c) - 35'(lo);
      b = 35'(hi) - 35'(c);
      aa = (a < 0) ? 35'(-a) : 35'(a);
      ab = (b < 0) ? 35'(-b) : 35'(b);
      face_dist = (aa < ab) ? aa : ab;
    end
  endfunction

  // True when the point lies below the box midpoint.
  function automatic logic below_mid(input logic signed [33:0] c,
                                     input logic signed [31:0] lo,
                                     input logic signed [31:0] hi);
    begin
      below_mid = (36'(c) <<< 1) < (36'(lo) + 36'(hi));
    end
  endfunction

  // Stage 1: input registers.
  logic               v1;
  logic signed [31:0] cx, cy, cz, lx, ly, lz, hx, hy, hz;
  logic [30:0]        hh1, r1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= take;
    end
    cx <= center_x;  cy <= center_y;  cz <= center_z;
    lx <= box_min_x; ly <= box_min_y; lz <= box_min_z;
    hx <= box_max_x; hy <= box_max_y; hz <= box_max_z;
    hh1 <= half_height;
    r1 <= radius;
  end

  // Stage 2: end points, clamped offsets, face distances and the Y span test.
  logic signed [33:0] top, bot, cx34, cz34, up, dn;
  logic signed [34:0] ex, ez, eyt, eyb;

  always_comb begin
    top  = 34'(cy) + $signed({3'b0, hh1});
    bot  = 34'(cy) - $signed({3'b0, hh1});
    cx34 = 34'(cx);
    cz34 = 34'(cz);
    ex   = clamp_d(cx34, lx, hx);
    ez   = clamp_d(cz34, lz, hz);
    eyt  = clamp_d(top, ly, hy);
    eyb  = clamp_d(bot, ly, hy);
    up   = (34'(hy) < top) ? 34'(hy) : top;
    dn   = (34'(ly) > bot) ? 34'(ly) : bot;
  end

  logic               v2, span2;
  logic signed [31:0] dx2, dz2, dyt2, dyb2;
  logic               okx2, okz2, okyt2, okyb2;
  logic [34:0]        fx2, fz2, fyt2, fyb2;
  logic               nx2, nz2, nyt2, nyb2;
  logic [30:0]        r2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    dx2 <= ex[31:0];   dz2 <= ez[31:0];
    dyt2 <= eyt[31:0]; dyb2 <= eyb[31:0];
    okx2 <= in_rng(ex, r1);   okz2 <= in_rng(ez, r1);
    okyt2 <= in_rng(eyt, r1); okyb2 <= in_rng(eyb, r1);
    fx2 <= face_dist(cx34, lx, hx);
    fz2 <= face_dist(cz34, lz, hz);
    fyt2 <= face_dist(top, ly, hy);
    fyb2 <= face_dist(bot, ly, hy);
    nx2 <= below_mid(cx34, lx, hx);
    nz2 <= below_mid(cz34, lz, hz);
    nyt2 <= below_mid(top, ly, hy);
    nyb2 <= below_mid(bot, ly, hy);
    span2 <= up > dn;
    r2 <= r1;
  end

  // Stage 3: squares of the offsets and of the radius.
  logic               v3, span3;
  logic [63:0]        sx3, sz3, syt3, syb3;
  logic [61:0]        rr3;
  logic signed [31:0] dx3, dz3, dyt3, dyb3;
  logic               okx3, okz3, okyt3, okyb3;
  logic [34:0]        fx3, fz3, fyt3, fyb3;
  logic               nx3, nz3, nyt3, nyb3;
  logic [30:0]        r3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= v2;
    end
    sx3  <= 64'(dx2 * dx2);
    sz3  <= 64'(dz2 * dz2);
    syt3 <= 64'(dyt2 * dyt2);
    syb3 <= 64'(dyb2 * dyb2);
    rr3  <= r2 * r2;
    dx3 <= dx2; dz3 <= dz2; dyt3 <= dyt2; dyb3 <= dyb2;
    okx3 <= okx2; okz3 <= okz2; okyt3 <= okyt2; okyb3 <= okyb2;
    fx3 <= fx2; fz3 <= fz2; fyt3 <= fyt2; fyb3 <= fyb2;
    nx3 <= nx2; nz3 <= nz2; nyt3 <= nyt2; nyb3 <= nyb2;
    span3 <= span2;
    r3 <= r2;
  end

  // Stage 4: squared lengths, hit checks and choice of the first test that hits.
  logic [63:0] l2t, l2b, l2s;
  logic        ht, hb, hs;

  always_comb begin
    l2t = sx3 + syt3 + sz3;
    l2b = sx3 + syb3 + sz3;
    l2s = sx3 + sz3;
    ht  = okx3 && okyt3 && okz3 && (l2t <= {2'b0, rr3});
    hb  = okx3 && okyb3 && okz3 && (l2b <= {2'b0, rr3});
    hs  = span3 && okx3 && okz3 && (l2s <= {2'b0, rr3});
  end

  logic               v4, hit4, usey4;
  logic [61:0]        l24;
  logic signed [31:0] dx4, dy4, dz4;
  logic [34:0]        fx4, fy4, fz4;
  logic               nx4, ny4, nz4;
  logic [30:0]        r4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else begin
      v4 <= v3;
    end
    hit4 <= ht || hb || hs;
    dx4 <= dx3; dz4 <= dz3; fx4 <= fx3; fz4 <= fz3; nx4 <= nx3; nz4 <= nz3;
    r4 <= r3;
    priority if (ht) begin
      usey4 <= 1'b1; l24 <= l2t[61:0]; dy4 <= dyt3; fy4 <= fyt3; ny4 <= nyt3;
    end else if (hb) begin
      usey4 <= 1'b1; l24 <= l2b[61:0]; dy4 <= dyb3; fy4 <= fyb3; ny4 <= nyb3;
    end else begin
      usey4 <= 1'b0; l24 <= l2s[61:0]; dy4 <= '0; fy4 <= fyt3; ny4 <= nyt3;
    end
  end

  // Stage 5: nearest face for a center inside the box, then hand over.
  axis_t       ax5;
  logic [34:0] f5;
  logic [35:0] dsum;

  always_comb begin
    if (usey4) begin
      if (fx4 <= fy4 && fx4 <= fz4) ax5 = AX_X;
      else if (fy4 <= fz4) ax5 = AX_Y;
      else ax5 = AX_Z;
    end else begin
      ax5 = (fx4 <= fz4) ? AX_X : AX_Z;
    end
    unique case (ax5)
      AX_X:    f5 = fx4;
      AX_Y:    f5 = fy4;
      default: f5 = fz4;
    endcase
    dsum = {5'b0, r4} + {1'b0, f5};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else begin
      push <= v4;
    end
    job.hit      <= hit4;
    job.interior <= (l24 == '0);
    job.l2       <= l24;
    job.dx       <= dx4;
    job.dy       <= dy4;
    job.dz       <= dz4;
    job.rad      <= r4;
    job.ax       <= ax5;
    unique case (ax5)
      AX_X:    job.neg <= nx4;
      AX_Y:    job.neg <= ny4;
      default: job.neg <= nz4;
    endcase
    job.dep_in <= (dsum > 36'(DEPTH_MAX)) ? DEPTH_MAX : dsum[30:0];
  end

endmodule

// ===== design/capab_fifo.sv =====
// Short queue of classified queries between the front and the back.
module capab_fifo import capab_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t wdata,
  input  logic pop,
  output job_t rdata,
  output logic empty,
  output logic full
);

  localparam int unsigned AW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

  job_t          mem [QDEPTH];
  logic [AW-1:0] wp, rp;
  logic [AW:0]   cnt;
  logic          do_push, do_pop;

  always_comb begin
    do_push = push && !full;
    do_pop  = pop && !empty;
    empty   = (cnt == '0);
    full    = (cnt == (AW+1)'(QDEPTH));
    rdata   = mem[rp];
  end

  // Storage written at the tail.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wp] <= wdata;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (do_push) begin
        wp <= (wp == AW'(QDEPTH - 1)) ? '0 : wp + 1'b1;
      end
      if (do_pop) begin
        rp <= (rp == AW'(QDEPTH - 1)) ? '0 : rp + 1'b1;
      end
      cnt <= cnt + (AW+1)'(do_push) - (AW+1)'(do_pop);
    end
  end

endmodule

// ===== design/capab_back.sv =====
// Back part: pipelined square root, normal division and result formatting.
module capab_back import capab_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               empty,
  input  job_t               head,
  output logic               pop,
  output logic               done,
  output logic               hit,
  output logic signed [17:0] normal_x,
  output logic signed [17:0] normal_y,
  output logic signed [17:0] normal_z,
  output logic [30:0]        depth
);

  localparam int unsigned SQ_STEPS  = 32;
  localparam int unsigned DIV_BITS  = 16;
  localparam int unsigned PREP      = SQ_STEPS + 1;
  localparam int unsigned NST       = PREP + DIV_BITS + 1;

  typedef struct packed {
    job_t              job;
    logic [63:0]       v;
    logic [63:0]       rt;
    logic [30:0]       len;
    logic [2:0]        sat;
    logic [2:0]        sgn;
    logic [2:0][31:0]  rem;
    logic [2:0][15:0]  quo;
  } bk_t;

  bk_t            st  [NST];
  bk_t            nxt [NST];
  logic [NST-1:0] vld;

  assign pop = !empty;

  // Magnitudes and signs of the offsets; a magnitude at or above the length saturates.
  logic signed [31:0] dsel [3];
  logic [31:0]        mag  [3];
  logic [30:0]        root;

  always_comb begin
    root    = st[SQ_STEPS].rt[30:0];
    dsel[0] = st[SQ_STEPS].job.dx;
    dsel[1] = st[SQ_STEPS].job.dy;
    dsel[2] = st[SQ_STEPS].job.dz;
    for (int i = 0; i < 3; i++) begin
      mag[i] = dsel[i][31] ? 32'(-dsel[i]) : 32'(dsel[i]);
    end
  end

  // Next contents of every stage: entry, square root steps, setup, quotient steps.
  always_comb begin
    logic [63:0] bitv;
    logic [63:0] trial;
    logic [31:0] r2;
    // The entry stage takes the head of the queue every cycle.
    nxt[0]     = '0;
    nxt[0].job = head;
    nxt[0].v   = {2'b0, head.l2};
    // One square root step per stage, most significant root bit first.
    for (int k = 0; k < SQ_STEPS; k++) begin
      bitv  = 64'd1 << (2 * (SQ_STEPS - 1 - k));
      trial = st[k].rt + bitv;
      nxt[k+1] = st[k];
      if (st[k].v >= trial) begin
        nxt[k+1].v  = st[k].v - trial;
        nxt[k+1].rt = (st[k].rt >> 1) + bitv;
      end else begin
        nxt[k+1].rt = st[k].rt >> 1;
      end
    end
    // Setup for the division.
    nxt[PREP]     = st[SQ_STEPS];
    nxt[PREP].len = root;
    for (int i = 0; i < 3; i++) begin
      nxt[PREP].sgn[i] = dsel[i][31];
      nxt[PREP].sat[i] = mag[i] >= {1'b0, root};
      nxt[PREP].rem[i] = mag[i];
      nxt[PREP].quo[i] = '0;
    end
    // One quotient bit per stage for all three components.
    for (int j = 0; j < DIV_BITS; j++) begin
      nxt[PREP+j+1] = st[PREP+j];
      for (int i = 0; i < 3; i++) begin
        r2 = {st[PREP+j].rem[i][30:0], 1'b0};
        if (r2 >= {1'b0, st[PREP+j].len}) begin
          nxt[PREP+j+1].rem[i] = r2 - {1'b0, st[PREP+j].len};
          nxt[PREP+j+1].quo[i] = {st[PREP+j].quo[i][14:0], 1'b1};
        end else begin
          nxt[PREP+j+1].rem[i] = r2;
          nxt[PREP+j+1].quo[i] = {st[PREP+j].quo[i][14:0], 1'b0};
        end
      end
    end
  end

  // Stage registers and their valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[NST-2:0], !empty};
    end
    st <= nxt;
  end

  // Result formatting.
  bk_t                fin;
  logic signed [17:0] nrm [3];
  logic [16:0]        qm  [3];

  always_comb begin
    fin = st[NST-1];
    for (int i = 0; i < 3; i++) begin
      qm[i]  = fin.sat[i] ? ONE_Q16 : {1'b0, fin.quo[i]};
      nrm[i] = fin.sgn[i] ? -$signed({1'b0, qm[i]}) : $signed({1'b0, qm[i]});
    end
    if (fin.job.interior) begin
      for (int i = 0; i < 3; i++) begin
        nrm[i] = '0;
      end
      unique case (fin.job.ax)
        AX_X:    nrm[0] = fin.job.neg ? -$signed({1'b0, ONE_Q16}) : $signed({1'b0, ONE_Q16});
        AX_Y:    nrm[1] = fin.job.neg ? -$signed({1'b0, ONE_Q16}) : $signed({1'b0, ONE_Q16});
        default: nrm[2] = fin.job.neg ? -$signed({1'b0, ONE_Q16}) : $signed({1'b0, ONE_Q16});
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vld[NST-1];
    end
    hit <= fin.job.hit;
    if (fin.job.hit) begin
      normal_x <= nrm[0];
      normal_y <= nrm[1];
      normal_z <= nrm[2];
      depth    <= fin.job.interior ? fin.job.dep_in : fin.job.rad - fin.len;
    end else begin
      normal_x <= '0;
      normal_y <= '0;
      normal_z <= '0;
      depth    <= '0;
    end
  end

endmodule

// ===== design/capsule_aabb_penetration_top.sv =====
// Top level of the capsule versus axis-aligned box penetration block.
// Takes one query per clock cycle while busy is low; each query gives exactly one
// result, shown for one cycle with done high, after the start transfer has passed
// through 5 classifier stages, the queue storage and entry register, 32 square root
// steps, 1 setup stage, 16 quotient steps and the output register. The square root
// and the normal division each give one bit per stage. Results come out in query
// order and cannot be held off; the solver drains the queue every cycle, so busy
// stays low.
module capsule_aabb_penetration_top import capab_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] center_x,
  input  logic signed [31:0] center_y,
  input  logic signed [31:0] center_z,
  input  logic [30:0]        half_height,
  input  logic [30:0]        radius,
  input  logic signed [31:0] box_min_x,
  input  logic signed [31:0] box_min_y,
  input  logic signed [31:0] box_min_z,
  input  logic signed [31:0] box_max_x,
  input  logic signed [31:0] box_max_y,
  input  logic signed [31:0] box_max_z,
  output logic               done,
  output logic               hit,
  output logic signed [17:0] normal_x,
  output logic signed [17:0] normal_y,
  output logic signed [17:0] normal_z,
  output logic [30:0]        depth
);

  logic push, pop, empty, full, take;
  job_t fjob, head;

  assign busy = full;
  assign take = start && !busy;

  // Classifier.
  capab_front u_front (
    .clk(clk), .rst(rst), .take(take),
    .center_x(center_x), .center_y(center_y), .center_z(center_z),
    .half_height(half_height), .radius(radius),
    .box_min_x(box_min_x), .box_min_y(box_min_y), .box_min_z(box_min_z),
    .box_max_x(box_max_x), .box_max_y(box_max_y), .box_max_z(box_max_z),
    .push(push), .job(fjob)
  );

  // Queue between the two parts.
  capab_fifo u_fifo (
    .clk(clk), .rst(rst), .push(push), .wdata(fjob),
    .pop(pop), .rdata(head), .empty(empty), .full(full)
  );

  // Solver.
  capab_back u_back (
    .clk(clk), .rst(rst), .empty(empty), .head(head), .pop(pop),
    .done(done), .hit(hit), .normal_x(normal_x), .normal_y(normal_y),
    .normal_z(normal_z), .depth(depth)
  );

endmodule
